[design/lfg_pkg.sv]
// ============================================================================
// lfg_pkg - shared types and constants for the largest free gap finder
// Request and result payloads, table write bundle and register map.
// ============================================================================
`default_nettype none

package lfg_pkg;

    localparam int unsigned LFG_MAX_ENTRIES = 16;
    localparam int unsigned APB_ADDR_W      = 5;
    localparam int unsigned APB_DATA_W      = 32;

    // Register map, one word per register.
    typedef enum logic [2:0] {
        REG_DISK_LOW_CYL  = 3'd0,
        REG_DISK_HIGH_CYL = 3'd1,
        REG_DISK_HEADS    = 3'd2,
        REG_DISK_SPT      = 3'd3,
        REG_RESERVED_BLKS = 3'd4
    } reg_idx_t;

    // Request opcodes.
    localparam logic CMD_ADD     = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [23:0] part_low_cyl;
        logic [23:0] part_high_cyl;
        logic [7:0]  part_surfaces;
        logic [7:0]  part_track_blocks;
    } req_t;

    typedef struct packed {
        logic [31:0] gap_low_block;
        logic [31:0] gap_high_block;
        logic        gap_found;
    } rsp_t;

    typedef struct packed {
        logic        we;
        logic [31:0] start_blk;
        logic [31:0] limit_blk;
    } tbl_wr_t;

endpackage

`default_nettype wire

[design/lfg_mul.sv]
// ============================================================================
// lfg_mul - shared block-count multiplier
// Multiplies a 32-bit operand by an 8-bit factor, result wrapped to 32 bits
// and registered. Every block product of the design goes through this unit.
// ============================================================================
`default_nettype none

module lfg_mul
    import lfg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [7:0]  b,
    output logic      [31:0] product
);

    logic [39:0] full;
    logic [31:0] product_reg;

    assign full    = {8'b0, a} * {32'b0, b};
    assign product = product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= full[31:0];
        end
    end

endmodule

`default_nettype wire

[design/lfg_table.sv]
// ============================================================================
// lfg_table - partition extent storage
// Start and limit block memories, one write port shared by both and one
// registered read port on each.
// ============================================================================
`default_nettype none

module lfg_table
    import lfg_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = LFG_MAX_ENTRIES,
    parameter int unsigned IDX_W       = 4
)
(
    input  wire logic             clk,
    input  wire tbl_wr_t          wr,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire logic [IDX_W-1:0] start_raddr,
    input  wire logic [IDX_W-1:0] limit_raddr,
    output logic      [31:0]      start_rdata,
    output logic      [31:0]      limit_rdata
);

    logic [31:0] start_mem [MAX_ENTRIES];
    logic [31:0] limit_mem [MAX_ENTRIES];
    logic [31:0] start_rdata_reg;
    logic [31:0] limit_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            start_mem[waddr] <= wr.start_blk;
            limit_mem[waddr] <= wr.limit_blk;
        end
        start_rdata_reg <= start_mem[start_raddr];
        limit_rdata_reg <= limit_mem[limit_raddr];
    end

    assign start_rdata = start_rdata_reg;
    assign limit_rdata = limit_rdata_reg;

endmodule

`default_nettype wire

[design/largest_free_gap_finder_core.sv]
// ============================================================================
// largest_free_gap_finder_core - largest free block range finder
// Stores partition extents as block ranges and scans them for the largest
// free gap on the disk, one stored entry per compare step.
// ============================================================================
// Add request: four shared-multiplier passes, then the table write; no result.
// Compute request with n stored entries: every stored start is compared against
// each of the n + 1 gap starts before the result strobe.
// One request at a time; the result strobe lasts one cycle and cannot stall.
// Reset clears control state, entry count, configuration and result registers;
// table contents and scratch registers stay undefined.
`default_nettype none

module largest_free_gap_finder_core
    import lfg_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = LFG_MAX_ENTRIES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire req_t                  request,
    output logic                       done,
    output rsp_t                       result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_M0,
        ST_ADD_M1,
        ST_ADD_M2,
        ST_ADD_M3,
        ST_ADD_WR,
        ST_END_M0,
        ST_END_M1,
        ST_END_SAVE,
        ST_CAND_RD,
        ST_CAND_LD,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EVAL,
        ST_DONE
    } state_t;

    // Configuration registers.
    logic [23:0] disk_low_cyl_reg;
    logic [23:0] disk_high_cyl_reg;
    logic [7:0]  disk_heads_reg;
    logic [7:0]  disk_spt_reg;
    logic [31:0] reserved_blocks_reg;

    // Sequencer and datapath registers.
    state_t     state_reg,     state_next;
    req_t       req_reg,       req_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cand_reg,  cand_next;
    logic [CNT_W-1:0] scan_reg,  scan_next;
    logic [31:0] start_tmp_reg,  start_tmp_next;
    logic [31:0] disk_end_reg,   disk_end_next;
    logic [31:0] from_reg,       from_next;
    logic [31:0] until_reg,      until_next;
    logic [31:0] best_low_reg,   best_low_next;
    logic [31:0] best_high_reg,  best_high_next;
    logic [31:0] best_size_reg,  best_size_next;
    logic        done_reg,       done_next;
    rsp_t        result_reg,     result_next;

    logic        accept;
    logic        cfg_write;
    reg_idx_t    cfg_idx;
    logic        mul_en;
    logic [31:0] mul_a;
    logic [7:0]  mul_b;
    logic [31:0] mul_p;
    tbl_wr_t     tbl_wr;
    logic [CNT_W-1:0] cand_m1;
    logic [31:0] start_rdata;
    logic [31:0] limit_rdata;
    logic [31:0] gap_size;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign result    = result_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);
    assign cand_m1   = cand_reg - CNT_W'(1);
    assign gap_size  = until_reg - from_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_low_cyl_reg    <= '0;
            disk_high_cyl_reg   <= '0;
            disk_heads_reg      <= 8'd1;
            disk_spt_reg        <= 8'd1;
            reserved_blocks_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_DISK_LOW_CYL:  disk_low_cyl_reg    <= pwdata[23:0];
                REG_DISK_HIGH_CYL: disk_high_cyl_reg   <= pwdata[23:0];
                REG_DISK_HEADS:    disk_heads_reg      <= pwdata[7:0];
                REG_DISK_SPT:      disk_spt_reg        <= pwdata[7:0];
                REG_RESERVED_BLKS: reserved_blocks_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_DISK_LOW_CYL:  prdata = {8'b0, disk_low_cyl_reg};
            REG_DISK_HIGH_CYL: prdata = {8'b0, disk_high_cyl_reg};
            REG_DISK_HEADS:    prdata = {24'b0, disk_heads_reg};
            REG_DISK_SPT:      prdata = {24'b0, disk_spt_reg};
            REG_RESERVED_BLKS: prdata = reserved_blocks_reg;
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier and extent table
    // ------------------------------------------------------------------
    lfg_mul u_mul (
        .clk     (clk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    lfg_table #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk         (clk),
        .wr          (tbl_wr),
        .waddr       (count_reg[IDX_W-1:0]),
        .start_raddr (scan_reg[IDX_W-1:0]),
        .limit_raddr (cand_m1[IDX_W-1:0]),
        .start_rdata (start_rdata),
        .limit_rdata (limit_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        cand_next      = cand_reg;
        scan_next      = scan_reg;
        start_tmp_next = start_tmp_reg;
        disk_end_next  = disk_end_reg;
        from_next      = from_reg;
        until_next     = until_reg;
        best_low_next  = best_low_reg;
        best_high_next = best_high_reg;
        best_size_next = best_size_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mul_en         = 1'b0;
        mul_a          = mul_p;
        mul_b          = req_reg.part_track_blocks;
        tbl_wr.we        = 1'b0;
        tbl_wr.start_blk = start_tmp_reg;
        tbl_wr.limit_blk = mul_p;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = request;
                    if (request.command == CMD_ADD)
                    begin
                        state_next = ST_ADD_M0;
                    end
                    else
                    begin
                        state_next = ST_END_M0;
                    end
                end
            end
            ST_ADD_M0:
            begin
                mul_en     = 1'b1;
                mul_a      = {8'b0, req_reg.part_low_cyl};
                mul_b      = req_reg.part_surfaces;
                state_next = ST_ADD_M1;
            end
            ST_ADD_M1:
            begin
                mul_en     = 1'b1;
                state_next = ST_ADD_M2;
            end
            ST_ADD_M2:
            begin
                start_tmp_next = mul_p;
                mul_en         = 1'b1;
                mul_a          = {8'b0, req_reg.part_high_cyl} + 32'd1;
                mul_b          = req_reg.part_surfaces;
                state_next     = ST_ADD_M3;
            end
            ST_ADD_M3:
            begin
                mul_en     = 1'b1;
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                // A full table silently drops the new extent.
                if (count_reg != CNT_W'(MAX_ENTRIES))
                begin
                    tbl_wr.we  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end
            ST_END_M0:
            begin
                mul_en     = 1'b1;
                mul_a      = {8'b0, disk_high_cyl_reg} - {8'b0, disk_low_cyl_reg} + 32'd1;
                mul_b      = disk_heads_reg;
                state_next = ST_END_M1;
            end
            ST_END_M1:
            begin
                mul_en     = 1'b1;
                mul_b      = disk_spt_reg;
                state_next = ST_END_SAVE;
            end
            ST_END_SAVE:
            begin
                disk_end_next  = mul_p;
                cand_next      = '0;
                best_low_next  = 32'd1;
                best_high_next = 32'd0;
                best_size_next = 32'd0;
                state_next     = ST_CAND_RD;
            end
            ST_CAND_RD:
            begin
                // The limit table address follows cand_reg; data lands next cycle.
                state_next = ST_CAND_LD;
            end
            ST_CAND_LD:
            begin
                from_next  = (cand_reg == '0) ? reserved_blocks_reg : limit_rdata;
                until_next = disk_end_reg;
                scan_next  = '0;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                if (scan_reg == count_reg)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (start_rdata >= from_reg && start_rdata < until_reg)
                begin
                    until_next = start_rdata;
                end
                scan_next  = scan_reg + CNT_W'(1);
                state_next = ST_SCAN_RD;
            end
            ST_EVAL:
            begin
                if (until_reg > from_reg && gap_size > best_size_reg)
                begin
                    best_low_next  = from_reg;
                    best_high_next = until_reg - 32'd1;
                    best_size_next = gap_size;
                end
                if (cand_reg == count_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cand_next  = cand_reg + CNT_W'(1);
                    state_next = ST_CAND_RD;
                end
            end
            ST_DONE:
            begin
                done_next                  = 1'b1;
                result_next.gap_low_block  = best_low_reg;
                result_next.gap_high_block = best_high_reg;
                result_next.gap_found      = !(best_low_reg == 32'd1 && best_high_reg == 32'd0);
                state_next                 = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cand_reg      <= '0;
            scan_reg      <= '0;
            best_low_reg  <= 32'd1;
            best_high_reg <= 32'd0;
            best_size_reg <= 32'd0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cand_reg      <= cand_next;
            scan_reg      <= scan_next;
            best_low_reg  <= best_low_next;
            best_high_reg <= best_high_next;
            best_size_reg <= best_size_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        start_tmp_reg <= start_tmp_next;
        disk_end_reg  <= disk_end_next;
        from_reg      <= from_next;
        until_reg     <= until_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_CMP) |-> (scan_reg < count_reg && cand_reg <= count_reg))
        else $error("scan index beyond stored entries");

    a_found_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.gap_found
                  || (result.gap_low_block == 32'd1 && result.gap_high_block == 32'd0)))
        else $error("empty result without the no-gap code");

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb - testbench for largest_free_gap_finder_core
// Loads partition extents and runs gap searches under many disk settings.
// Each search result is predicted from a local copy of the extent table and
// the disk registers, and every result strobe is checked field by field.
// ============================================================================

module tb;
    import lfg_pkg::*;

    localparam int unsigned CYCLE_LIMIT       = 3_000_000;
    localparam int unsigned DRAIN_CYCLES      = 650;
    localparam int unsigned SEARCHES_PER_MODE = 420;

    typedef struct packed {
        logic hold_for_drain;
        req_t req;
    } pending_req_t;

    logic                  clk;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    req_t                  request = '0;
    logic                  done;
    rsp_t                  result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    largest_free_gap_finder_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Disk registers and extent table as the block should hold them.
    bit [31:0] cfg_low_cyl  = 32'd0;
    bit [31:0] cfg_high_cyl = 32'd0;
    bit [31:0] cfg_heads    = 32'd1;
    bit [31:0] cfg_spt      = 32'd1;
    bit [31:0] cfg_reserved = 32'd0;
    bit [31:0] part_start_blk [LFG_MAX_ENTRIES];
    bit [31:0] part_limit_blk [LFG_MAX_ENTRIES];
    int        part_count = 0;

    pending_req_t request_q[$];
    rsp_t         gap_expect_q[$];
    int           send_idle_pct = 0;
    int           error_count   = 0;
    int unsigned  cycle_count   = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void store_extent(input req_t r);
        bit [31:0] lo_cyl;
        bit [31:0] hi_cyl;
        bit [31:0] surf;
        bit [31:0] blks;
        lo_cyl = r.part_low_cyl;
        hi_cyl = r.part_high_cyl;
        surf   = r.part_surfaces;
        blks   = r.part_track_blocks;
        // A full table drops further extents.
        if (part_count < LFG_MAX_ENTRIES)
        begin
            part_start_blk[part_count] = lo_cyl * surf * blks;
            part_limit_blk[part_count] = (hi_cyl + 32'd1) * surf * blks;
            part_count++;
        end
    endfunction

    function automatic rsp_t largest_gap();
        rsp_t      r;
        bit [31:0] disk_end;
        bit [31:0] gap_start;
        bit [31:0] gap_end;
        bit [31:0] best_lo;
        bit [31:0] best_hi;
        int        g;
        int        k;
        disk_end = (cfg_high_cyl - cfg_low_cyl + 32'd1) * cfg_heads * cfg_spt;
        best_lo  = 32'd1;
        best_hi  = 32'd0;
        for (g = 0; g <= part_count; g++)
        begin
            gap_start = (g == 0) ? cfg_reserved : part_limit_blk[g-1];
            gap_end   = disk_end;
            for (k = 0; k < part_count; k++)
            begin
                if (part_start_blk[k] >= gap_start && part_start_blk[k] < gap_end)
                    gap_end = part_start_blk[k];
            end
            // An end at or below the start is no gap; the wrapped difference is not used.
            if (gap_end > gap_start && (gap_end - gap_start) > (best_hi - best_lo + 32'd1))
            begin
                best_lo = gap_start;
                best_hi = gap_end - 32'd1;
            end
        end
        r.gap_low_block  = best_lo;
        r.gap_high_block = best_hi;
        r.gap_found      = !(best_lo == 32'd1 && best_hi == 32'd0);
        return r;
    endfunction

    function automatic req_t extent(input bit [23:0] lo, hi, input bit [7:0] sf, bt);
        req_t r;
        r.command           = CMD_ADD;
        r.part_low_cyl      = lo;
        r.part_high_cyl     = hi;
        r.part_surfaces     = sf;
        r.part_track_blocks = bt;
        return r;
    endfunction

    // The extent fields of a search request are don't-care, so they carry noise.
    function automatic req_t gap_query();
        req_t r;
        r.command           = CMD_COMPUTE;
        r.part_low_cyl      = 24'($urandom);
        r.part_high_cyl     = 24'($urandom);
        r.part_surfaces     = 8'($urandom);
        r.part_track_blocks = 8'($urandom);
        return r;
    endfunction

    task automatic enqueue(input req_t r, input bit hold);
        pending_req_t p;
        p.hold_for_drain = hold;
        p.req            = r;
        request_q.push_back(p);
    endtask

    task automatic reg_write(input reg_idx_t idx, input bit [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DISK_LOW_CYL:  cfg_low_cyl  = value & 32'h00FF_FFFF;
            REG_DISK_HIGH_CYL: cfg_high_cyl = value & 32'h00FF_FFFF;
            REG_DISK_HEADS:    cfg_heads    = value & 32'h0000_00FF;
            REG_DISK_SPT:      cfg_spt      = value & 32'h0000_00FF;
            REG_RESERVED_BLKS: cfg_reserved = value;
            default: ;
        endcase
    endtask

    task automatic set_disk(input bit [31:0] low_cyl, high_cyl, heads, spt, rsv_blocks);
        reg_write(REG_DISK_LOW_CYL, low_cyl);
        reg_write(REG_DISK_HIGH_CYL, high_cyl);
        reg_write(REG_DISK_HEADS, heads);
        reg_write(REG_DISK_SPT, spt);
        reg_write(REG_RESERVED_BLKS, rsv_blocks);
        @(negedge clk);
    endtask

    // Waits until every request is accepted and answered and the block is idle.
    task automatic settle();
        do @(negedge clk);
        while (request_q.size() != 0 || start || gap_expect_q.size() != 0 || busy);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive_requests
        logic go;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            go = start;
            if (start && !busy)
            begin
                if (request.command == CMD_COMPUTE)
                    gap_expect_q.push_back(largest_gap());
                else
                    store_extent(request);
                go = 1'b0;
            end
            if (!go && request_q.size() != 0 && $urandom_range(99) >= send_idle_pct
                && (!request_q[0].hold_for_drain || gap_expect_q.size() == 0))
            begin
                request <= request_q[0].req;
                request_q.pop_front();
                go = 1'b1;
            end
            start <= go;
        end
    end

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && done)
        begin
            if (gap_expect_q.size() == 0)
            begin
                $error("result with no search pending: low %0d high %0d found %0b",
                       result.gap_low_block, result.gap_high_block, result.gap_found);
                error_count++;
            end
            else
            begin
                want = gap_expect_q.pop_front();
                if (result.gap_low_block !== want.gap_low_block)
                begin
                    $error("gap_low_block: expected %0d, got %0d",
                           want.gap_low_block, result.gap_low_block);
                    error_count++;
                end
                if (result.gap_high_block !== want.gap_high_block)
                begin
                    $error("gap_high_block: expected %0d, got %0d",
                           want.gap_high_block, result.gap_high_block);
                    error_count++;
                end
                if (result.gap_found !== want.gap_found)
                begin
                    $error("gap_found: expected %0b, got %0b",
                           want.gap_found, result.gap_found);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        req_t      r;
        bit [31:0] lo;
        bit [31:0] hi;
        bit [31:0] heads;
        bit [31:0] spt;
        bit [31:0] rsv;
        int        mode;
        int        pick;
        int        searches;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // 1008 blocks per cylinder, 1000 cylinders.
        set_disk(0, 999, 16, 63, 63);
        r = '0;
        r.command = CMD_COMPUTE;
        enqueue(r, 1'b0);
        r = '1;
        r.command = CMD_COMPUTE;
        enqueue(r, 1'b0);
        enqueue(extent(1, 99, 16, 63), 1'b0);
        enqueue(gap_query(), 1'b1);
        enqueue(extent(100, 199, 16, 63), 1'b0);   // abuts the previous extent
        enqueue(extent(500, 599, 16, 63), 1'b0);
        enqueue(gap_query(), 1'b0);
        enqueue(extent(24'hFF_FFFF, 24'hFF_FFFF, 8'hFF, 8'hFF), 1'b0);
        enqueue(extent(0, 0, 1, 1), 1'b0);
        enqueue(extent(800, 999, 16, 63), 1'b0);   // ends exactly at the disk end
        enqueue(extent(300, 349, 16, 63), 1'b0);
        enqueue(extent(320, 420, 16, 63), 1'b0);   // overlaps the previous extent
        enqueue(gap_query(), 1'b0);
        enqueue(extent(650, 660, 16, 63), 1'b0);
        enqueue(extent(700, 749, 8, 126), 1'b0);
        enqueue(extent(1000, 1099, 16, 63), 1'b0); // lies past the disk end
        enqueue(extent(450, 459, 128, 1), 1'b0);
        enqueue(extent(610, 619, 1, 128), 1'b0);
        enqueue(extent(24'hFF_FFFF, 0, 1, 1), 1'b0);
        enqueue(extent(900, 949, 16, 63), 1'b0);
        enqueue(extent(200, 249, 16, 63), 1'b0);   // table is now full
        enqueue(gap_query(), 1'b0);
        enqueue(extent(24'hFF_FFFF, 24'hFF_FFFF, 8'hFF, 8'hFF), 1'b0);
        enqueue(gap_query(), 1'b0);
        settle();

        // Zero heads, then zero blocks per track, give an empty disk.
        set_disk(0, 999, 0, 63, 63);
        enqueue(gap_query(), 1'b0);
        settle();
        set_disk(0, 999, 16, 0, 0);
        enqueue(gap_query(), 1'b0);
        settle();

        for (mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 77 : 0;
            searches = 0;
            while (searches < SEARCHES_PER_MODE)
            begin
                pick = $urandom_range(9);
                if (pick <= 5)
                begin
                    // Disks shaped like the one the extents were laid out on.
                    lo    = ($urandom_range(3) == 0) ? $urandom_range(60) : 0;
                    hi    = $urandom_range(1300, lo);
                    heads = 16;
                    spt   = 63;
                    if ($urandom_range(4) == 0)
                        heads = $urandom_range(1, 32);
                    case ($urandom_range(3))
                        0: rsv = part_start_blk[$urandom_range(part_count - 1)]
                                 + $urandom_range(2) - 1;
                        1: rsv = part_limit_blk[$urandom_range(part_count - 1)]
                                 + $urandom_range(2) - 1;
                        2: rsv = $urandom_range(2016);
                        default: rsv = $urandom_range(1_400_000);
                    endcase
                end
                else if (pick <= 7)
                begin
                    lo    = $urandom;
                    hi    = $urandom;
                    heads = $urandom;
                    spt   = $urandom;
                    rsv   = $urandom;
                end
                else
                begin
                    lo    = $urandom_range(1) ? 32'h00FF_FFFF : 32'd0;
                    hi    = $urandom_range(1) ? 32'h00FF_FFFF : 32'd0;
                    heads = $urandom_range(1) ? 32'd255 : 32'd1;
                    spt   = $urandom_range(1) ? 32'd255 : 32'd1;
                    rsv   = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
                end
                set_disk(lo, hi, heads, spt, rsv);
                repeat ($urandom_range(3, 10))
                begin
                    if ($urandom_range(9) == 0)
                        enqueue(extent(24'($urandom), 24'($urandom),
                                       8'($urandom), 8'($urandom)), 1'b0);
                    else
                    begin
                        enqueue(gap_query(), $urandom_range(24) == 0);
                        searches++;
                    end
                end
                settle();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[files.f]
design/lfg_pkg.sv
design/lfg_mul.sv
design/lfg_table.sv
design/largest_free_gap_finder_core.sv
tb/tb.sv
